>>> src/fps2d_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the five-point stencil unit.
// No dependencies; imported by five_point_stencil_2d_unit.
package fps2d_pkg;

	// Largest grid that the line buffers hold
	localparam int unsigned MAX_COLS = 2048;
	localparam int unsigned MAX_ROWS = 4096;

	// Field widths fixed by the interface
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COEF_W   = 16;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned COL_W    = 11;
	localparam int unsigned GCOLS_W  = 12;
	localparam int unsigned GROWS_W  = 13;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned IDX_W    = 3;

	// Line buffer address width
	localparam int unsigned COL_AW = $clog2(MAX_COLS);

	// Output item: value, row, column, packed to whole bytes
	localparam int unsigned OUT_BITS = SAMPLE_W + ROW_W + COL_W;
	localparam int unsigned OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

	// Q1.14 rounding
	localparam int unsigned FRAC_BITS = 14;
	localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;
	localparam int unsigned SUM_W     = PROD_W + 3;
	localparam int unsigned QUO_W     = SUM_W - FRAC_BITS;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_GRID_COLS   = 3'd0,
		REG_GRID_ROWS   = 3'd1,
		REG_COEF_UP     = 3'd2,
		REG_COEF_LEFT   = 3'd3,
		REG_COEF_CENTER = 3'd4,
		REG_COEF_RIGHT  = 3'd5,
		REG_COEF_DOWN   = 3'd6
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [GCOLS_W-1:0] GRID_COLS_RST = GCOLS_W'(2048);
	localparam logic [GROWS_W-1:0] GRID_ROWS_RST = GROWS_W'(2048);
	localparam logic signed [COEF_W-1:0] COEF_RST = COEF_W'(3277);

	// Smallest usable grid
	localparam int unsigned MIN_DIM = 3;

endpackage

>>> src/five_point_stencil_2d_unit.sv
`timescale 1ns / 1ps
// Five-point star stencil over a raster sample stream, two line buffers.
// Depends on fps2d_pkg.
//
// Path: the item that completes a neighborhood reads the line buffers into
// stage 1, then the product stage multiplies and the output register takes the sum.
// One item per cycle unless m_tready stalls; single-write, single-read buffers.
// Reset: position, window registers and valid flags clear, configuration
// returns to its defaults; line buffers are not cleared and need no sweep.
module five_point_stencil_2d_unit
	import fps2d_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	input  logic                s_tuser,   // frame_start
	// output stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_TW-1:0]   m_tdata,   // [15:0] stencil_value, [27:16] out_row,
	                                       // [38:28] out_col, [39] zero
	output logic                m_tlast    // frame_done
);

	// Configuration registers
	logic [GCOLS_W-1:0]        grid_cols_q;
	logic [GROWS_W-1:0]        grid_rows_q;
	logic signed [COEF_W-1:0]  coef_up_q, coef_left_q, coef_center_q;
	logic signed [COEF_W-1:0]  coef_right_q, coef_down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q   <= GRID_COLS_RST;
			grid_rows_q   <= GRID_ROWS_RST;
			coef_up_q     <= COEF_RST;
			coef_left_q   <= COEF_RST;
			coef_center_q <= COEF_RST;
			coef_right_q  <= COEF_RST;
			coef_down_q   <= COEF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_COLS:   grid_cols_q   <= cfg_data[GCOLS_W-1:0];
				REG_GRID_ROWS:   grid_rows_q   <= cfg_data[GROWS_W-1:0];
				REG_COEF_UP:     coef_up_q     <= cfg_data;
				REG_COEF_LEFT:   coef_left_q   <= cfg_data;
				REG_COEF_CENTER: coef_center_q <= cfg_data;
				REG_COEF_RIGHT:  coef_right_q  <= cfg_data;
				REG_COEF_DOWN:   coef_down_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped geometry
	logic [GCOLS_W-1:0] cols;
	logic [GROWS_W-1:0] rows;

	always_comb begin
		if (grid_cols_q < GCOLS_W'(MIN_DIM))
			cols = GCOLS_W'(MIN_DIM);
		else if (grid_cols_q > GCOLS_W'(MAX_COLS))
			cols = GCOLS_W'(MAX_COLS);
		else
			cols = grid_cols_q;
		if (grid_rows_q < GROWS_W'(MIN_DIM))
			rows = GROWS_W'(MIN_DIM);
		else if (grid_rows_q > GROWS_W'(MAX_ROWS))
			rows = GROWS_W'(MAX_ROWS);
		else
			rows = grid_rows_q;
	end

	// Handshake chain: output register, product stage, read stage
	logic m_valid_q;
	logic s1_v, s2_v;
	logic out_load, s2_free, s1_adv, in_acc;

	assign out_load = s2_v && (!m_valid_q || m_tready);
	assign s2_free  = !s2_v || out_load;
	assign s1_adv   = s1_v && s2_free;
	assign s_tready = !s1_v || s1_adv;
	assign in_acc   = s_tvalid && s_tready;

	// Raster position of the incoming item and of the next one
	logic [ROW_W-1:0]   row_q, r0, r_in, row_nx;
	logic [COL_AW-1:0]  col_q, c0, c_in, col_nx;
	logic [ROW_W:0]     r1, rn;
	logic [GCOLS_W-1:0] cn;

	always_comb begin
		r0 = s_tuser ? '0 : row_q;
		c0 = s_tuser ? '0 : col_q;
		if (GCOLS_W'(c0) >= cols) begin
			c_in = '0;
			r1   = (ROW_W+1)'(r0) + 1'b1;
		end else begin
			c_in = c0;
			r1   = (ROW_W+1)'(r0);
		end
		r_in = (GROWS_W'(r1) >= rows) ? '0 : r1[ROW_W-1:0];
		// advance past this item
		cn = GCOLS_W'(c_in) + 1'b1;
		rn = (ROW_W+1)'(r_in) + 1'b1;
		if (cn >= cols) begin
			col_nx = '0;
			row_nx = (GROWS_W'(rn) >= rows) ? '0 : rn[ROW_W-1:0];
		end else begin
			col_nx = cn[COL_AW-1:0];
			row_nx = r_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

	// Stage 1 payload: sample, position, flags, forwarded line data
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [COL_AW-1:0]          c_s1;
	logic [ROW_W-1:0]           row_out_s1;
	logic [COL_W-1:0]           col_out_s1;
	logic                       prod_s1, last_s1, fwd_s1;
	logic signed [SAMPLE_W-1:0] fwd_up_s1, fwd_mid_s1;
	logic signed [SAMPLE_W-1:0] up_rd_s1, mid_rd_s1;
	logic signed [SAMPLE_W-1:0] up_c, mid_c;

	// Line buffer data seen by stage 1, with the write of the item ahead forwarded
	assign up_c  = fwd_s1 ? fwd_up_s1  : up_rd_s1;
	assign mid_c = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v <= 1'b0;
		else if (in_acc)
			s1_v <= 1'b1;
		else if (s1_adv)
			s1_v <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1       <= s_tdata;
			c_s1       <= c_in;
			row_out_s1 <= r_in - 1'b1;
			col_out_s1 <= COL_W'(c_in) - 1'b1;
			prod_s1    <= (r_in >= ROW_W'(2)) && (c_in >= COL_AW'(2));
			last_s1    <= (GROWS_W'(r_in) == rows - 1'b1) &&
			              (GCOLS_W'(c_in) == cols - 1'b1);
			fwd_s1     <= s1_v && (c_s1 == c_in);
			fwd_up_s1  <= mid_c;
			fwd_mid_s1 <= x_s1;
		end
	end

	// Line buffers: read at item accept, written when stage 1 moves on
	logic [SAMPLE_W-1:0] upper_mem  [MAX_COLS];
	logic [SAMPLE_W-1:0] middle_mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			upper_mem[c_s1]  <= mid_c;
			middle_mem[c_s1] <= x_s1;
		end
		if (in_acc) begin
			up_rd_s1  <= upper_mem[c_in];
			mid_rd_s1 <= middle_mem[c_in];
		end
	end

	// Window registers around the cell
	logic signed [SAMPLE_W-1:0] mid_w1_q, mid_w2_q, upper_delay_q, cur_delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_w1_q      <= '0;
			mid_w2_q      <= '0;
			upper_delay_q <= '0;
			cur_delay_q   <= '0;
		end else if (s1_adv) begin
			mid_w1_q      <= mid_w2_q;
			mid_w2_q      <= mid_c;
			upper_delay_q <= up_c;
			cur_delay_q   <= x_s1;
		end
	end

	// Stage 2: five products
	logic signed [PROD_W-1:0] p_up_s2, p_left_s2, p_center_s2, p_right_s2, p_down_s2;
	logic [ROW_W-1:0]         row_s2;
	logic [COL_W-1:0]         col_s2;
	logic                     last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v <= 1'b0;
		else if (s1_adv)
			s2_v <= prod_s1;
		else if (out_load)
			s2_v <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			p_up_s2     <= upper_delay_q * coef_up_q;
			p_left_s2   <= mid_w1_q * coef_left_q;
			p_center_s2 <= mid_w2_q * coef_center_q;
			p_right_s2  <= mid_c * coef_right_q;
			p_down_s2   <= cur_delay_q * coef_down_q;
			row_s2      <= row_out_s1;
			col_s2      <= col_out_s1;
			last_s2     <= last_s1;
		end
	end

	// Sum, round half up, floor shift, saturate
	logic signed [SUM_W-1:0]    acc_sum;
	logic signed [QUO_W-1:0]    quo;
	logic signed [SAMPLE_W-1:0] value;

	always_comb begin
		acc_sum = SUM_W'(p_up_s2) + SUM_W'(p_left_s2) + SUM_W'(p_center_s2)
		        + SUM_W'(p_right_s2) + SUM_W'(p_down_s2)
		        + SUM_W'(1 << (FRAC_BITS - 1));
		quo = QUO_W'(acc_sum >>> FRAC_BITS);
		if (quo > QUO_W'(32767))
			value = 16'sh7FFF;
		else if (quo < -QUO_W'(32768))
			value = 16'sh8000;
		else
			value = quo[SAMPLE_W-1:0];
	end

	// Output register
	logic signed [SAMPLE_W-1:0] value_q;
	logic [ROW_W-1:0]           row_q3;
	logic [COL_W-1:0]           col_q3;
	logic                       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= value;
			row_q3  <= row_s2;
			col_q3  <= col_s2;
			last_q  <= last_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TW'({col_q3, row_q3, value_q});
	assign m_tlast  = last_q;

	// A stalled stage 1 keeps its column and line data
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !s1_adv |=> s1_v && $stable(c_s1) && $stable(up_rd_s1))
		else $error("stage 1 lost its item while stalled");

	// Every accepted item occupies stage 1 in the next cycle
	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_v)
		else $error("accepted item missing from stage 1");

	// A product stage result waits until the output register takes it
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v && !out_load |=> s2_v && $stable(row_s2) && $stable(col_s2))
		else $error("product stage result dropped");

	// Results only come from interior cells
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (row_q3 != '0) && (col_q3 != '0))
		else $error("result for a border cell");

	// Stored column position stays inside the line buffer and differs from stage 1's
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (GCOLS_W'(col_q) < GCOLS_W'(MAX_COLS)) && (col_q != c_s1))
		else $error("column position did not advance");

endmodule
